>>> sv/dast_pkg.sv
// shared types, codes and constants for the daily alarm slot table
// depends on nothing; used by dast_ctrl, dast_datapath and the top level

package dast_pkg;

   localparam int SLOT_COUNT_DEF = 8;

   // field widths
   localparam int OP_W         = 3;
   localparam int TIME_W       = 32;
   localparam int ID_W         = 32;
   localparam int MIN_W        = 16;
   localparam int SLOT_FIELD_W = 3;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 4;
   localparam int KIND_W       = 2;
   localparam int PROD_W       = 22;

   // request word layout
   localparam int NOW_LSB    = 0;
   localparam int ID_LSB     = 32;
   localparam int ASEC_LSB   = 64;
   localparam int MIN_LSB    = 96;
   localparam int REP_BIT    = 112;
   localparam int SLOT_LSB   = 113;
   localparam int REQ_DATA_W = 120;

   // response word layout
   localparam int RSP_PAD_W  = 2;
   localparam int RSP_DATA_W = 16;

   localparam logic [TIME_W-1:0] DAY_SECONDS    = 32'd86400;
   localparam logic [5:0]        MINUTE_SECONDS = 6'd60;

   typedef enum logic [OP_W-1:0] {
      OP_TICK         = 3'd0,
      OP_ADD_SHUTDOWN = 3'd1,
      OP_ADD_DELAY    = 3'd2,
      OP_ADD_POWERUP  = 3'd3,
      OP_CANCEL_ID    = 3'd4,
      OP_CANCEL_SLOT  = 3'd5,
      OP_MODIFY       = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_DUP_ID    = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_BAD_SLOT  = 3'd4
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SHUTDOWN = 2'd0,
      KIND_POWERUP  = 2'd1,
      KIND_DELAY    = 2'd2
   } kind_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

>>> sv/dast_ctrl.sv
// sequencer for the alarm slot table: accept, scan, finish
// depends on dast_pkg for the command and status structs

module dast_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  dast_pkg::dp_stat_type stat,
   output dast_pkg::dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for room in the response register
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/dast_datapath.sv
// slot storage, scan evaluation and response register of the alarm slot table
// depends on dast_pkg; driven by dast_ctrl through dp_cmd_type

module dast_datapath #(
   parameter int SLOT_COUNT = dast_pkg::SLOT_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dast_pkg::dp_cmd_type                cmd,
   output dast_pkg::dp_stat_type               stat,
   input  logic [dast_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [dast_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dast_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W  =
      ((SLOT_W > dast_pkg::SLOT_FIELD_W) ? SLOT_W : dast_pkg::SLOT_FIELD_W) + 1;
   localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

   // captured request word
   dast_pkg::op_type                    op_ff;
   logic [dast_pkg::TIME_W-1:0]         now_ff;
   logic [dast_pkg::ID_W-1:0]           id_ff;
   logic [dast_pkg::TIME_W-1:0]         asec_ff;
   logic [dast_pkg::MIN_W-1:0]          mins_ff;
   logic                                rep_ff;
   logic [dast_pkg::SLOT_FIELD_W-1:0]   slot_ff;

   // delayed shutdown end time, two registered steps
   logic [dast_pkg::PROD_W-1:0]         prod_ff;
   logic [dast_pkg::TIME_W-1:0]         delay_end_ff;

   // slot storage
   logic [SLOT_COUNT-1:0]               valid_ff;
   logic [SLOT_COUNT-1:0]               valid_in;
   logic [dast_pkg::ID_W-1:0]           id_mem   [SLOT_COUNT];
   logic [dast_pkg::TIME_W-1:0]         end_mem  [SLOT_COUNT];
   logic [dast_pkg::KIND_W-1:0]         kind_mem [SLOT_COUNT];
   logic                                rep_mem  [SLOT_COUNT];
   logic [dast_pkg::ID_W-1:0]           id_rd_ff;
   logic [dast_pkg::TIME_W-1:0]         end_rd_ff;
   logic [dast_pkg::KIND_W-1:0]         kind_rd_ff;
   logic                                rep_rd_ff;

   // scan sequencing
   logic [CNT_W-1:0]                    rd_cnt_ff;
   logic                                ev_vld_ff;
   logic [SLOT_W-1:0]                   ev_idx_ff;
   logic                                rd_en;
   logic [SLOT_W-1:0]                   rd_addr;
   logic                                ev;

   // scan results
   logic [dast_pkg::COUNT_W-1:0]        sfire_ff, sfire_in;
   logic [dast_pkg::COUNT_W-1:0]        bfire_ff, bfire_in;
   logic                                dup_ff, dup_in;
   logic                                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]                   free_idx_ff, free_idx_in;
   logic                                found_ff, found_in;

   // write port
   logic [SLOT_W-1:0]                   wr_addr;
   logic                                id_we, end_we, kind_we, rep_we;
   logic [dast_pkg::TIME_W-1:0]         end_wd;
   logic [dast_pkg::KIND_W-1:0]         kind_wd;
   logic                                rep_wd;

   // response register
   logic                                rsp_valid_ff;
   logic [dast_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [dast_pkg::SLOT_FIELD_W-1:0]   rsp_used_ff;
   logic [dast_pkg::COUNT_W-1:0]        rsp_sfire_ff;
   logic [dast_pkg::COUNT_W-1:0]        rsp_bfire_ff;
   dast_pkg::status_type                status_c;
   logic [dast_pkg::SLOT_FIELD_W-1:0]   used_c;

   // slot evaluation terms
   logic                                slot_v;
   logic                                eff_v;
   logic                                is_add;
   logic                                hit;
   logic                                due;
   logic [CMP_W-1:0]                    sl_ext;
   logic                                sl_ok;
   logic [SLOT_W-1:0]                   sl_idx;

   assign rd_en   = cmd.scan && (rd_cnt_ff != LAST_CNT);
   assign rd_addr = rd_cnt_ff[SLOT_W-1:0];
   assign ev      = cmd.scan && ev_vld_ff;

   assign slot_v = valid_ff[ev_idx_ff];
   // a delayed shutdown add treats earlier delay slots as already dropped
   assign eff_v  = slot_v && !((op_ff == dast_pkg::OP_ADD_DELAY) &&
                               (kind_rd_ff == dast_pkg::KIND_DELAY));
   assign is_add = (op_ff == dast_pkg::OP_ADD_SHUTDOWN) ||
                   (op_ff == dast_pkg::OP_ADD_DELAY) ||
                   (op_ff == dast_pkg::OP_ADD_POWERUP);
   assign hit    = (now_ff == end_rd_ff);
   assign due    = (now_ff >= end_rd_ff);
   assign sl_ext = CMP_W'(slot_ff);
   assign sl_ok  = (sl_ext < CMP_W'(SLOT_COUNT));
   assign sl_idx = SLOT_W'(slot_ff);

   assign stat.scan_done = ev && (ev_idx_ff == LAST_IDX);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      valid_in      = valid_ff;
      sfire_in      = sfire_ff;
      bfire_in      = bfire_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      found_in      = found_ff;
      wr_addr       = ev_idx_ff;
      id_we         = 1'b0;
      end_we        = 1'b0;
      kind_we       = 1'b0;
      rep_we        = 1'b0;
      end_wd        = end_rd_ff + dast_pkg::DAY_SECONDS;
      kind_wd       = dast_pkg::KIND_SHUTDOWN;
      rep_wd        = rep_ff;
      status_c      = dast_pkg::STAT_OK;
      used_c        = '0;

      if (cmd.capture) begin
         sfire_in      = '0;
         bfire_in      = '0;
         dup_in        = 1'b0;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         found_in      = 1'b0;
      end

      if (ev) begin
         unique case (op_ff) inside
            dast_pkg::OP_TICK: begin
               if (slot_v) begin
                  if (hit) begin
                     if ((kind_rd_ff == dast_pkg::KIND_SHUTDOWN) ||
                         (kind_rd_ff == dast_pkg::KIND_DELAY)) begin
                        sfire_in = sfire_ff + 1'b1;
                     end else if (kind_rd_ff == dast_pkg::KIND_POWERUP) begin
                        bfire_in = bfire_ff + 1'b1;
                     end
                  end
                  if (due) begin
                     if (rep_rd_ff) begin
                        end_we = 1'b1;
                     end else begin
                        valid_in[ev_idx_ff] = 1'b0;
                     end
                  end
               end
            end
            dast_pkg::OP_ADD_SHUTDOWN, dast_pkg::OP_ADD_DELAY,
            dast_pkg::OP_ADD_POWERUP: begin
               if (slot_v && !eff_v) begin
                  valid_in[ev_idx_ff] = 1'b0;
               end
               if (eff_v && (id_rd_ff == id_ff)) begin
                  dup_in = 1'b1;
               end
               if (!eff_v && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = ev_idx_ff;
               end
            end
            dast_pkg::OP_CANCEL_ID: begin
               if (slot_v && (id_rd_ff == id_ff) && !found_ff) begin
                  found_in            = 1'b1;
                  valid_in[ev_idx_ff] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.finish) begin
         unique case (op_ff) inside
            dast_pkg::OP_ADD_SHUTDOWN, dast_pkg::OP_ADD_DELAY,
            dast_pkg::OP_ADD_POWERUP: begin
               if (dup_ff) begin
                  status_c = dast_pkg::STAT_DUP_ID;
               end else if (!free_found_ff) begin
                  status_c = dast_pkg::STAT_FULL;
               end else begin
                  wr_addr  = free_idx_ff;
                  id_we    = 1'b1;
                  end_we   = 1'b1;
                  kind_we  = 1'b1;
                  rep_we   = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  used_c   = dast_pkg::SLOT_FIELD_W'(free_idx_ff);
                  if (op_ff == dast_pkg::OP_ADD_DELAY) begin
                     end_wd  = delay_end_ff;
                     kind_wd = dast_pkg::KIND_DELAY;
                     rep_wd  = 1'b0;
                  end else begin
                     end_wd  = asec_ff;
                     kind_wd = (op_ff == dast_pkg::OP_ADD_POWERUP) ?
                               dast_pkg::KIND_POWERUP : dast_pkg::KIND_SHUTDOWN;
                  end
               end
            end
            dast_pkg::OP_CANCEL_ID: begin
               if (!found_ff) begin
                  status_c = dast_pkg::STAT_NOT_FOUND;
               end
            end
            dast_pkg::OP_CANCEL_SLOT: begin
               if (sl_ok) begin
                  valid_in[sl_idx] = 1'b0;
               end else begin
                  status_c = dast_pkg::STAT_BAD_SLOT;
               end
            end
            dast_pkg::OP_MODIFY: begin
               if (sl_ok && valid_ff[sl_idx]) begin
                  wr_addr = sl_idx;
                  end_we  = 1'b1;
                  rep_we  = 1'b1;
                  end_wd  = asec_ff;
               end else begin
                  status_c = dast_pkg::STAT_BAD_SLOT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // request capture and delay end time
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= dast_pkg::op_type'(req_tuser);
         now_ff  <= req_tdata[dast_pkg::NOW_LSB +: dast_pkg::TIME_W];
         id_ff   <= req_tdata[dast_pkg::ID_LSB +: dast_pkg::ID_W];
         asec_ff <= req_tdata[dast_pkg::ASEC_LSB +: dast_pkg::TIME_W];
         mins_ff <= req_tdata[dast_pkg::MIN_LSB +: dast_pkg::MIN_W];
         rep_ff  <= req_tdata[dast_pkg::REP_BIT];
         slot_ff <= req_tdata[dast_pkg::SLOT_LSB +: dast_pkg::SLOT_FIELD_W];
      end
      prod_ff      <= dast_pkg::PROD_W'(mins_ff) *
                      dast_pkg::PROD_W'(dast_pkg::MINUTE_SECONDS);
      delay_end_ff <= now_ff + dast_pkg::TIME_W'(prod_ff);
   end

   // slot memories, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[wr_addr] <= id_ff;
      end
      if (end_we) begin
         end_mem[wr_addr] <= end_wd;
      end
      if (kind_we) begin
         kind_mem[wr_addr] <= kind_wd;
      end
      if (rep_we) begin
         rep_mem[wr_addr] <= rep_wd;
      end
      if (rd_en) begin
         id_rd_ff   <= id_mem[rd_addr];
         end_rd_ff  <= end_mem[rd_addr];
         kind_rd_ff <= kind_mem[rd_addr];
         rep_rd_ff  <= rep_mem[rd_addr];
      end
   end

   // scan pointer and per-item results
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_cnt_ff     <= '0;
         ev_vld_ff     <= 1'b0;
         ev_idx_ff     <= '0;
         sfire_ff      <= '0;
         bfire_ff      <= '0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         found_ff      <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         sfire_ff      <= sfire_in;
         bfire_ff      <= bfire_in;
         dup_ff        <= dup_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
         found_ff      <= found_in;
         if (cmd.capture) begin
            rd_cnt_ff <= '0;
            ev_vld_ff <= 1'b0;
         end else if (cmd.scan) begin
            ev_vld_ff <= rd_en;
            if (rd_en) begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
               ev_idx_ff <= rd_addr;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_c;
         rsp_used_ff   <= used_c;
         rsp_sfire_ff  <= sfire_ff;
         rsp_bfire_ff  <= bfire_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{dast_pkg::RSP_PAD_W{1'b0}}, rsp_bfire_ff, rsp_sfire_ff,
                        rsp_used_ff, rsp_status_ff};

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= LAST_CNT)
      else $error("scan pointer ran past the table");

   a_fires_tick_only: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && (op_ff != dast_pkg::OP_TICK)) |=>
      ((rsp_sfire_ff == '0) && (rsp_bfire_ff == '0)))
      else $error("fire count reported on a non-tick word");

   a_add_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && is_add && !dup_ff && free_found_ff) |=>
      valid_ff[$past(free_idx_ff)])
      else $error("successful add left its slot invalid");

   a_err_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != dast_pkg::STAT_OK)) |->
      (rsp_used_ff == '0))
      else $error("failed word reports a slot");

endmodule

>>> sv/daily_alarm_slot_table_core.sv
// daily alarm slot table: top level, sequencer plus slot datapath
// depends on dast_pkg, dast_ctrl and dast_datapath
// every word scans all SLOT_COUNT slots through one registered memory read port,
// one slot a cycle; the response register is loaded once the scan is done and the
// register is free, and a new word is taken only after that, back in idle
// synchronous active-high reset empties the table and drops any pending response

module daily_alarm_slot_table_core #(
   parameter int SLOT_COUNT = dast_pkg::SLOT_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request word
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_sec[31:0], timer_id[63:32], alarm_sec[95:64], delay_minutes[111:96],
   // repeat_daily[112], slot[115:113], zero pad[119:116]
   input  logic [dast_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[2:0]
   input  logic [dast_pkg::OP_W-1:0]        req_tuser,
   // response word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[2:0], slot_used[5:3], shutdown_fires[9:6], boot_fires[13:10],
   // zero pad[15:14]
   output logic [dast_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // command and status between sequencer and datapath
   dast_pkg::dp_cmd_type  cmd;
   dast_pkg::dp_stat_type stat;

   // sequencer: idle, scan of all slots, finish into the response register
   dast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // slot memories, valid flags, scan evaluation and response register
   dast_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> test/daily_alarm_slot_table_core_test.sv
// self-checking testbench for daily_alarm_slot_table_core: directed and random words,
// predicted table state in a small scoreboard class, random idling on both channels
// depends on dast_pkg and the daily_alarm_slot_table_core rtl

module daily_alarm_slot_table_core_test;
   import dast_pkg::*;

   localparam int SLOTS          = SLOT_COUNT_DEF;
   localparam int RANDOM_WORDS   = 825;
   localparam int DIRECTED_WORDS = 25;
   localparam int TOTAL_WORDS    = RANDOM_WORDS + DIRECTED_WORDS;
   localparam int QUIET_TAIL     = 120;   // words at the end sent with no idling
   localparam int LONG_HOLD      = 400;   // receiver hold-off that backs up the input
   localparam int HOLD_AT        = 300;   // responses checked before the long hold
   localparam int STALL_LIMIT    = 3000;  // cycles with no transfer on either side
   localparam int MAX_REPORTS    = 10;

   // operation code outside the defined set, ignored by the block
   localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SLOT_FIELD_W-1:0] slot_used;
      logic [COUNT_W-1:0]      shutdown_fires;
      logic [COUNT_W-1:0]      boot_fires;
   } outcome_type;

   // predicted table plus the queue of outcomes still owed by the block
   class slot_table_scoreboard;
      logic                    slot_on    [SLOTS];
      logic [ID_W-1:0]         slot_tag   [SLOTS];
      logic [TIME_W-1:0]       slot_due   [SLOTS];
      kind_type                slot_sort  [SLOTS];
      logic                    slot_daily [SLOTS];
      outcome_type             owed_outcomes [$];
      int                      mismatches;
      int                      checked;
      int                      op_seen [8];
      int                      status_seen [8];
      int                      shutdown_total;
      int                      boot_total;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_on[i]    = 1'b0;
            slot_tag[i]   = '0;
            slot_due[i]   = '0;
            slot_sort[i]  = KIND_SHUTDOWN;
            slot_daily[i] = 1'b0;
         end
         mismatches = 0;
         checked = 0;
         shutdown_total = 0;
         boot_total = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // cancel and expiry keep kind and repeat, only the rest goes to zero
      function void clear_entry(int i);
         slot_on[i]  = 1'b0;
         slot_tag[i] = '0;
         slot_due[i] = '0;
      endfunction

      // duplicate check first, then the lowest free slot
      function logic [STATUS_W-1:0] place_alarm(logic [ID_W-1:0] tag, logic [TIME_W-1:0] due,
                                                kind_type sort, logic daily,
                                                output logic [SLOT_FIELD_W-1:0] used);
         used = '0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_on[i] && slot_tag[i] == tag) return STAT_DUP_ID;
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_on[i]) begin
               slot_on[i]    = 1'b1;
               slot_tag[i]   = tag;
               slot_due[i]   = due;
               slot_sort[i]  = sort;
               slot_daily[i] = daily;
               used = SLOT_FIELD_W'(i);
               return STAT_OK;
            end
         end
         return STAT_FULL;
      endfunction

      function outcome_type predict_outcome(logic [OP_W-1:0] op, logic [TIME_W-1:0] now_sec,
                                            logic [ID_W-1:0] tag, logic [TIME_W-1:0] alarm_sec,
                                            logic [MIN_W-1:0] minutes, logic daily,
                                            logic [SLOT_FIELD_W-1:0] slot);
         outcome_type       res;
         logic [TIME_W-1:0] due;
         res = '0;
         case (op)
            OP_TICK: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_on[i]) begin
                     if (now_sec == slot_due[i]) begin
                        if (slot_sort[i] == KIND_SHUTDOWN || slot_sort[i] == KIND_DELAY)
                           res.shutdown_fires++;
                        else if (slot_sort[i] == KIND_POWERUP)
                           res.boot_fires++;
                     end
                     if (now_sec >= slot_due[i]) begin
                        if (slot_daily[i]) slot_due[i] = slot_due[i] + DAY_SECONDS;
                        else clear_entry(i);
                     end
                  end
               end
            end
            OP_ADD_SHUTDOWN:
               res.status = place_alarm(tag, alarm_sec, KIND_SHUTDOWN, daily, res.slot_used);
            OP_ADD_DELAY: begin
               // earlier delay slots drop out even when the add is then rejected
               for (int i = 0; i < SLOTS; i++)
                  if (slot_on[i] && slot_sort[i] == KIND_DELAY) slot_on[i] = 1'b0;
               due = now_sec + TIME_W'(minutes) * TIME_W'(MINUTE_SECONDS);
               res.status = place_alarm(tag, due, KIND_DELAY, 1'b0, res.slot_used);
            end
            OP_ADD_POWERUP:
               res.status = place_alarm(tag, alarm_sec, KIND_POWERUP, daily, res.slot_used);
            OP_CANCEL_ID: begin
               res.status = STAT_NOT_FOUND;
               for (int i = 0; i < SLOTS; i++) begin
                  if (res.status == STAT_NOT_FOUND && slot_on[i] && slot_tag[i] == tag) begin
                     clear_entry(i);
                     res.status = STAT_OK;
                  end
               end
            end
            OP_CANCEL_SLOT: begin
               if (int'(slot) >= SLOTS) res.status = STAT_BAD_SLOT;
               else clear_entry(int'(slot));
            end
            OP_MODIFY: begin
               if (int'(slot) >= SLOTS || !slot_on[int'(slot)]) begin
                  res.status = STAT_BAD_SLOT;
               end else begin
                  slot_due[int'(slot)]   = alarm_sec;
                  slot_daily[int'(slot)] = daily;
               end
            end
            default: ;
         endcase
         if (res.status != STAT_OK) res.slot_used = '0;
         return res;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] now_sec,
                                 logic [ID_W-1:0] tag, logic [TIME_W-1:0] alarm_sec,
                                 logic [MIN_W-1:0] minutes, logic daily,
                                 logic [SLOT_FIELD_W-1:0] slot);
         outcome_type res;
         res = predict_outcome(op, now_sec, tag, alarm_sec, minutes, daily, slot);
         op_seen[op]++;
         status_seen[res.status]++;
         shutdown_total += res.shutdown_fires;
         boot_total += res.boot_fires;
         owed_outcomes.push_back(res);
      endfunction

      function void flag_mismatch(string what, logic [RSP_DATA_W-1:0] want,
                                  logic [RSP_DATA_W-1:0] got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                     checked, what, want, got);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] word);
         outcome_type want;
         outcome_type got;
         got = word[STATUS_W+SLOT_FIELD_W+2*COUNT_W-1:0] ;
         got.status         = word[2:0];
         got.slot_used      = word[5:3];
         got.shutdown_fires = word[9:6];
         got.boot_fires     = word[13:10];
         checked++;
         if (owed_outcomes.size() == 0) begin
            flag_mismatch("response with nothing owed", '0, word);
            return;
         end
         want = owed_outcomes.pop_front();
         if (got.status != want.status)
            flag_mismatch("status", RSP_DATA_W'(want.status), RSP_DATA_W'(got.status));
         if (got.slot_used != want.slot_used)
            flag_mismatch("slot_used", RSP_DATA_W'(want.slot_used),
                          RSP_DATA_W'(got.slot_used));
         if (got.shutdown_fires != want.shutdown_fires)
            flag_mismatch("shutdown_fires", RSP_DATA_W'(want.shutdown_fires),
                          RSP_DATA_W'(got.shutdown_fires));
         if (got.boot_fires != want.boot_fires)
            flag_mismatch("boot_fires", RSP_DATA_W'(want.boot_fires),
                          RSP_DATA_W'(got.boot_fires));
      endfunction

      function int pending();
         return owed_outcomes.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [OP_W-1:0]         req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   slot_table_scoreboard    sb = new();
   int                      words_sent = 0;
   logic [TIME_W-1:0]       wall_sec;    // running time used to build ticks and alarms

   daily_alarm_slot_table_core #(
      .SLOT_COUNT (SLOTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // offer one word, hold it until taken, then maybe leave a gap
   // valid stays high across back-to-back words, so it is assigned once per edge
   task automatic send_word(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_sec,
                            input logic [ID_W-1:0] tag, input logic [TIME_W-1:0] alarm_sec,
                            input logic [MIN_W-1:0] minutes, input logic daily,
                            input logic [SLOT_FIELD_W-1:0] slot);
      // data layout from bit 0 up: now_sec, timer_id, alarm_sec, delay_minutes,
      // repeat_daily, slot, zero pad
      req_tdata  <= {4'b0, slot, daily, minutes, alarm_sec, tag, now_sec};
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, now_sec, tag, alarm_sec, minutes, daily, slot);
      words_sent++;
      // random gaps on the sender side, none in the closing stretch
      if (words_sent < TOTAL_WORDS - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // fills the table, hits every reject code, the delay replacement rules,
   // a full-table tick and a daily re-arm that wraps past 2^32
   task automatic send_directed_words();
      send_word(OP_TICK, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 3'd0);
      send_word(OP_ADD_SHUTDOWN, 32'd0, 32'd0, 32'd100, 16'd0, 1'b0, 3'd0);
      send_word(OP_ADD_SHUTDOWN, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 1'b1, 3'd0);
      send_word(OP_ADD_POWERUP, 32'd0, 32'hFFFF_FFFF, 32'd100, 16'd0, 1'b1, 3'd7);
      // delay end is now plus a minute; repeat request is dropped
      send_word(OP_ADD_DELAY, 32'd40, 32'd5, 32'd0, 16'd1, 1'b1, 3'd0);
      // replaces the previous delay slot, end time wraps
      send_word(OP_ADD_DELAY, 32'hFFFF_FFFF, 32'd6, 32'd0, 16'hFFFF, 1'b0, 3'd0);
      send_word(OP_CANCEL_ID, 32'd0, 32'd6, 32'd0, 16'd0, 1'b0, 3'd0);
      send_word(OP_CANCEL_ID, 32'd0, 32'd12345, 32'd0, 16'd0, 1'b0, 3'd0);
      send_word(OP_MODIFY, 32'd0, 32'd0, 32'd55, 16'd0, 1'b1, 3'd7);
      send_word(OP_MODIFY, 32'd0, 32'd0, 32'd100, 16'd0, 1'b1, 3'd0);
      send_word(OP_ADD_POWERUP, 32'd0, 32'd10, 32'd100, 16'd0, 1'b0, 3'd0);
      send_word(OP_ADD_SHUTDOWN, 32'd0, 32'd11, 32'd100, 16'd0, 1'b1, 3'd0);
      send_word(OP_ADD_DELAY, 32'd100, 32'd12, 32'd0, 16'd0, 1'b0, 3'd0);
      send_word(OP_ADD_POWERUP, 32'd0, 32'd13, 32'd100, 16'd0, 1'b0, 3'd0);
      send_word(OP_ADD_SHUTDOWN, 32'd0, 32'd14, 32'd100, 16'd0, 1'b0, 3'd0);
      send_word(OP_ADD_POWERUP, 32'd0, 32'd15, 32'd100, 16'd0, 1'b1, 3'd0);
      // table now full
      send_word(OP_ADD_SHUTDOWN, 32'd0, 32'd16, 32'd100, 16'd0, 1'b0, 3'd0);
      // delay slot is dropped although the id is a duplicate
      send_word(OP_ADD_DELAY, 32'd100, 32'd13, 32'd0, 16'd0, 1'b0, 3'd0);
      send_word(OP_ADD_DELAY, 32'd100, 32'd17, 32'd0, 16'd0, 1'b0, 3'd0);
      // every slot fires at once
      send_word(OP_TICK, 32'd100, 32'd0, 32'd0, 16'd0, 1'b0, 3'd0);
      send_word(OP_MODIFY, 32'd0, 32'd0, 32'hFFFF_FFF0, 16'd0, 1'b1, 3'd3);
      send_word(OP_TICK, 32'hFFFF_FFF0, 32'd0, 32'd0, 16'd0, 1'b0, 3'd0);
      send_word(OP_CANCEL_SLOT, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 3'd3);
      send_word(OP_CANCEL_SLOT, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 3'd3);
      send_word(OP_RESERVED, $urandom, $urandom, $urandom, 16'hA5C3, 1'b1, 3'd5);
   endtask

   // mostly well-formed traffic around a running clock with a small id pool,
   // so that duplicates, full tables, cancels and firing ticks keep happening
   task automatic send_random_word();
      logic [OP_W-1:0]         op;
      logic [TIME_W-1:0]       now_sec;
      logic [ID_W-1:0]         tag;
      logic [TIME_W-1:0]       alarm_sec;
      logic [MIN_W-1:0]        minutes;
      logic                    daily;
      logic [SLOT_FIELD_W-1:0] slot;
      int                      pick;
      pick      = $urandom_range(0, 99);
      tag       = $urandom_range(0, 11);
      if ($urandom_range(0, 9) == 0) tag = $urandom;
      alarm_sec = wall_sec + $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) alarm_sec = $urandom;
      minutes   = MIN_W'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) minutes = MIN_W'($urandom);
      daily     = 1'($urandom_range(0, 1));
      slot      = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
      if (pick < 28) begin
         op = OP_TICK;
         wall_sec = wall_sec + $urandom_range(0, 3);
         // jump about a day so that re-armed alarms come round again
         if ($urandom_range(0, 24) == 0)
            wall_sec = wall_sec + DAY_SECONDS - $urandom_range(0, 6);
         if ($urandom_range(0, 59) == 0) wall_sec = $urandom;
      end else if (pick < 43) begin
         op = OP_ADD_SHUTDOWN;
      end else if (pick < 52) begin
         op = OP_ADD_DELAY;
      end else if (pick < 66) begin
         op = OP_ADD_POWERUP;
      end else if (pick < 76) begin
         op = OP_CANCEL_ID;
      end else if (pick < 82) begin
         op = OP_CANCEL_SLOT;
      end else if (pick < 92) begin
         op = OP_MODIFY;
      end else begin
         op = OP_TICK;
      end
      now_sec = wall_sec;
      // noise: every field at random, reserved code included
      if (pick >= 92) begin
         op        = OP_W'($urandom_range(0, 7));
         now_sec   = $urandom;
         tag       = $urandom;
         alarm_sec = $urandom;
         minutes   = MIN_W'($urandom);
      end
      send_word(op, now_sec, tag, alarm_sec, minutes, daily, slot);
   endtask

   // response side: checks each word, idles in random bursts and once holds off long
   initial begin : response_sink
      int  stall_left;
      bit  long_hold_done;
      stall_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && sb.checked >= HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (!reset && sb.checked < TOTAL_WORDS - QUIET_TAIL
                      && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ends the run if neither channel moves a word for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("timeout: no word moved for %0d cycles, %0d responses still owed",
               STALL_LIMIT, sb.pending());
      $display("daily_alarm_slot_table_core test failed");
      $finish;
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_directed_words();
      wall_sec = 32'hFFFF_FE00;   // random phase starts just short of the wrap
      repeat (RANDOM_WORDS) send_random_word();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      // a stray extra word would show up within a few scan times
      repeat (4 * (SLOTS + 3)) @(posedge clock);
      $display("ran %0d words: %0d ticks, %0d adds, %0d cancels, %0d modifies, %0d reserved",
               words_sent, sb.op_seen[OP_TICK],
               sb.op_seen[OP_ADD_SHUTDOWN] + sb.op_seen[OP_ADD_DELAY] +
               sb.op_seen[OP_ADD_POWERUP],
               sb.op_seen[OP_CANCEL_ID] + sb.op_seen[OP_CANCEL_SLOT], sb.op_seen[OP_MODIFY],
               sb.op_seen[OP_RESERVED]);
      $display("%0d responses checked; fires: %0d shutdown, %0d boot", sb.checked,
               sb.shutdown_total, sb.boot_total);
      $display("rejects: %0d duplicate, %0d full, %0d unknown id, %0d bad slot",
               sb.status_seen[STAT_DUP_ID], sb.status_seen[STAT_FULL],
               sb.status_seen[STAT_NOT_FOUND], sb.status_seen[STAT_BAD_SLOT]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("daily_alarm_slot_table_core test passed");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("daily_alarm_slot_table_core test failed");
      end
      $finish;
   end

endmodule
